@@ rtl/unsigned_restoring_divider_top_macros.svh @@
// Assertion macros for the divider, all clocked on i_clk and
// disabled while i_rst_n is low.
`ifndef UNSIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH
`define UNSIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH

// Same-cycle implication
`define URD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define URD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/urd_pkg.sv @@
`timescale 1ns / 1ps

package urd_pkg;

    // Default datapath width in bits (allowed 4 to 64)
    localparam int DEFAULT_WIDTH = 32;

endpackage

@@ rtl/urd_cell.sv @@
`timescale 1ns / 1ps

// One restoring step: shift in the next dividend bit, trial subtract,
// record the quotient bit in the vacated low bit of the dividend word.
module urd_cell #(
    parameter int WIDTH = urd_pkg::DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // upstream side
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_acc,
    input  logic [WIDTH-1:0] i_den,
    // downstream side
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_acc,
    output logic [WIDTH-1:0] o_den
);

    logic             r_valid;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_den;

    logic [WIDTH-1:0] w_shift;
    logic             w_ge;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_acc;

    // Stage can load when empty or when its beat leaves this cycle
    assign o_ready = !r_valid || i_ready;

    // Shift/compare/subtract; the partial remainder MSB is always zero here
    always_comb begin
        w_shift = {i_rem[WIDTH-2:0], i_acc[WIDTH-1]};
        w_ge    = (w_shift >= i_den);
        n_rem   = w_ge ? (w_shift - i_den) : w_shift;
        n_acc   = {i_acc[WIDTH-2:0], w_ge};
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_den <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_den   = r_den;

endmodule

@@ rtl/unsigned_restoring_divider_top.sv @@
`timescale 1ns / 1ps
// Path: a beat is registered in each of the WIDTH step cells in turn and then
// in the output register before it leaves as an output beat.
// Throughput: one beat per cycle while the output takes beats; each cell holds
// one beat, so WIDTH + 1 beats can be in flight; a stall backs up cell by cell.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.

`include "unsigned_restoring_divider_top_macros.svh"

module unsigned_restoring_divider_top #(
    parameter int WIDTH = urd_pkg::DEFAULT_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // dividend [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH], zero pad above
    input  logic [((2*WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // quotient [WIDTH-1:0], remainder [2*WIDTH-1:WIDTH], zero pad above
    output logic [((2*WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready
);

    localparam int TDATA_W = ((2*WIDTH+7)/8)*8;

    // Links between cells; link k feeds cell k
    logic             w_valid [WIDTH+1];
    logic             w_ready [WIDTH+1];
    logic [WIDTH-1:0] w_rem   [WIDTH+1];
    logic [WIDTH-1:0] w_acc   [WIDTH+1];
    logic [WIDTH-1:0] w_den   [WIDTH+1];

    logic             r_out_valid;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;

    // Input beat enters the first cell with a zero partial remainder
    assign w_valid[0]    = s_axis_tvalid;
    assign w_rem[0]      = '0;
    assign w_acc[0]      = s_axis_tdata[WIDTH-1:0];
    assign w_den[0]      = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign s_axis_tready = w_ready[0];

    // Chain of step cells, one quotient bit each, MSB first
    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        urd_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_acc   (w_acc[k]),
            .i_den   (w_den[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_den   (w_den[k+1])
        );
    end

    // Output register; zero divisor forces both results to zero
    assign w_ready[WIDTH] = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[WIDTH]) begin
            r_out_valid <= w_valid[WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[WIDTH] && w_ready[WIDTH]) begin
            if (w_den[WIDTH] == '0) begin
                r_quo <= '0;
                r_rem <= '0;
            end else begin
                r_quo <= w_acc[WIDTH];
                r_rem <= w_rem[WIDTH];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_rem, r_quo});

    // Input only stalls when the whole chain is full and the output is blocked
    `URD_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready,
        w_valid[1] && w_valid[WIDTH] && r_out_valid && !m_axis_tready,
        "input stalled with room in the chain")
    // Final partial remainder is below a nonzero divisor
    `URD_ASSERT_IMPL(a_rem_below_den, w_valid[WIDTH] && (w_den[WIDTH] != '0),
        w_rem[WIDTH] < w_den[WIDTH], "remainder not below divisor")
    // A beat taken from the last cell shows up at the output
    `URD_ASSERT_NEXT(a_out_loaded, w_valid[WIDTH] && w_ready[WIDTH], m_axis_tvalid,
        "output register lost a beat")

endmodule

@@ bench/unsigned_restoring_divider_top_tb.sv @@
`timescale 1ns / 1ps

module unsigned_restoring_divider_top_tb;

    localparam int W       = urd_pkg::DEFAULT_WIDTH;
    localparam int DW      = ((2*W+7)/8)*8;
    localparam int LATENCY = W + 1;

    typedef logic [W-1:0] t_word;
    // Packed so it maps straight onto tdata: quotient low, remainder high
    typedef struct packed {
        t_word remainder;
        t_word quotient;
    } t_div_result;

    logic          i_clk;
    logic          i_rst_n;
    logic [DW-1:0] s_axis_tdata;   // dividend, divisor, zero pad
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] m_axis_tdata;   // quotient, remainder, zero pad
    logic          m_axis_tvalid;
    logic          m_axis_tready;

    t_div_result   expected_divisions[$];
    int unsigned   mismatch_count     = 0;
    bit            sender_gaps_on     = 1'b1;
    bit            receiver_stalls_on = 1'b1;
    int unsigned   burst_left         = 0;
    int unsigned   hold_off_cycles    = 0;

    unsigned_restoring_divider_top #(
        .WIDTH(W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Shift-subtract division, one quotient bit per step, MSB first.
    // Divide by zero gives zero quotient and zero remainder.
    function automatic t_div_result restoring_divide(t_word dividend, t_word divisor);
        t_div_result res;
        t_word       partial;
        res     = '0;
        partial = '0;
        if (divisor != '0) begin
            for (int i = W - 1; i >= 0; i--) begin
                partial = {partial[W-2:0], dividend[i]};
                if (partial >= divisor) begin
                    partial         = partial - divisor;
                    res.quotient[i] = 1'b1;
                end
            end
            res.remainder = partial;
        end
        return res;
    endfunction

    // Random value of at most 'bits' significant bits
    function automatic t_word random_word(int unsigned bits);
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if (bits == 0)
            return '0;
        return t_word'(raw >> (64 - bits));
    endfunction

    // Offer one beat; bursts of random length separated by random gaps
    task automatic send_operands(input t_word dividend, input t_word divisor);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = sender_gaps_on ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= DW'({$urandom(), $urandom()});
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'({divisor, dividend});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_divisions.push_back(restoring_divide(dividend, divisor));
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_divisions.size() != 0);
        burst_left = 0;
    endtask

    // Operand extremes, zero divisor, equal operands, dividend below divisor
    task automatic test_directed();
        t_word all_ones;
        t_word msb;
        all_ones = '1;
        msb      = t_word'(1) << (W - 1);
        send_operands('0, '0);
        send_operands(all_ones, '0);
        send_operands(t_word'(5), '0);
        send_operands('0, t_word'(1));
        send_operands('0, all_ones);
        send_operands(all_ones, t_word'(1));
        send_operands(all_ones, all_ones);
        send_operands(t_word'(1), all_ones);
        send_operands(all_ones - 1'b1, all_ones);
        send_operands(all_ones, all_ones - 1'b1);
        send_operands(all_ones, t_word'(2));
        send_operands(msb, t_word'(1));
        send_operands(msb, msb);
        send_operands(msb - 1'b1, msb);
        send_operands(all_ones, msb);
        send_operands(t_word'(1), t_word'(1));
        send_operands(t_word'(100), t_word'(10));
        send_operands(t_word'(12345), t_word'(7));
        send_operands(t_word'(7), t_word'(12345));
        send_operands(all_ones, t_word'(16'hffff));
        send_operands(t_word'(32'h5555_5555), t_word'(3));
        send_operands(t_word'(32'haaaa_aaaa), t_word'(32'h5555_5555));
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure_fill();
        sender_gaps_on  = 1'b0;
        hold_off_cycles = 4 * LATENCY + 20;
        repeat (80)
            send_operands(random_word(W), random_word($urandom_range(1, W)));
        sender_gaps_on = 1'b1;
    endtask

    // Sender waits for a full drain, then a stretch with no idling anywhere
    task automatic test_drain_then_stream();
        pause_until_drained();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        repeat (60)
            send_operands(random_word(W), random_word($urandom_range(1, W)));
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Random operands of mixed magnitude; idling changes from chunk to chunk
    task automatic test_random_operands();
        t_word       dividend;
        t_word       divisor;
        int unsigned kind;
        for (int chunk = 0; chunk < 8; chunk++) begin
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (85) begin
                dividend = random_word(($urandom_range(0, 3) == 0) ?
                                       $urandom_range(1, W) : W);
                kind = $urandom_range(0, 15);
                case (kind)
                    0:       divisor = '0;
                    1:       divisor = dividend;
                    2:       divisor = dividend + 1'b1;
                    3:       divisor = random_word($urandom_range(1, 4));
                    4, 5, 6, 7, 8, 9:
                             divisor = random_word($urandom_range(1, W));
                    default: divisor = random_word(W);
                endcase
                send_operands(dividend, divisor);
            end
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Receiver: random ready/stall segments, or a requested hold-off
    initial begin
        int unsigned seg_left;
        bit          seg_ready;
        seg_left      = 0;
        seg_ready     = 1'b1;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_ready = ($urandom_range(0, 3) != 0);
                    seg_left  = seg_ready ? $urandom_range(1, 20) : $urandom_range(1, 8);
                end
                seg_left--;
                m_axis_tready <= seg_ready || !receiver_stalls_on;
            end
        end
    end

    // Compare each output beat with the oldest expected division
    always @(posedge i_clk) begin
        t_div_result want;
        t_div_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[2*W-1:0];
            if (expected_divisions.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual q=%h r=%h",
                         $time, got.quotient, got.remainder);
                mismatch_count++;
            end else begin
                want = expected_divisions.pop_front();
                if (got.quotient !== want.quotient) begin
                    $display("%0t: quotient mismatch, expected %h, actual %h",
                             $time, want.quotient, got.quotient);
                    mismatch_count++;
                end
                if (got.remainder !== want.remainder) begin
                    $display("%0t: remainder mismatch, expected %h, actual %h",
                             $time, want.remainder, got.remainder);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure_fill();
        test_drain_then_stream();
        test_random_operands();

        pause_until_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_divisions.size() == 0)
            $display("** unsigned_restoring_divider_top: PASSED **");
        else
            $display("** unsigned_restoring_divider_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("** unsigned_restoring_divider_top: FAILED **");
        $finish;
    end

endmodule
